@@ rtl/bole_pkg.sv @@
// Package for the bounded ordered list engine.
// Holds the request and status codes and the controller/datapath struct types.
// No dependencies.
package bole_pkg;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INS_FIRST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_LAST  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch and check a new request
    logic rd_ins;   // read the entry below the insert cursor
    logic wr_ins;   // move read data up one place, cursor down
    logic wr_val;   // write the new value at the insert point
    logic rd_at;    // read the entry to be deleted
    logic cap;      // capture removed value, cursor to delete point
    logic rd_del;   // read the entry above the delete cursor
    logic wr_del;   // move read data down one place, cursor up
    logic finish;   // update count and present the result
  } bole_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_ins;   // accepted insert that will succeed
    logic op_del;   // accepted delete that will succeed
    logic more;     // another entry must still be moved
  } bole_stat_t;

endpackage

@@ rtl/bole_ctrl.sv @@
// Controller for the bounded ordered list engine.
// Sequences the per-entry moves of the datapath; depends on bole_pkg.
module bole_ctrl
  import bole_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  bole_stat_t stat,
  output bole_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_INS_TEST = 3'd2;
  localparam logic [2:0] S_INS_WR   = 3'd3;
  localparam logic [2:0] S_DEL_CAP  = 3'd4;
  localparam logic [2:0] S_DEL_TEST = 3'd5;
  localparam logic [2:0] S_DEL_WR   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op_ins) begin
          state_nxt = S_INS_TEST;
        end else if (stat.op_del) begin
          cmd.rd_at = 1'b1;
          state_nxt = S_DEL_CAP;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_INS_TEST: begin
        if (stat.more) begin
          cmd.rd_ins = 1'b1;
          state_nxt  = S_INS_WR;
        end else begin
          cmd.wr_val = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd.wr_ins = 1'b1;
        state_nxt  = S_INS_TEST;
      end
      S_DEL_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_DEL_TEST;
      end
      S_DEL_TEST: begin
        if (stat.more) begin
          cmd.rd_del = 1'b1;
          state_nxt  = S_DEL_WR;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DEL_WR: begin
        cmd.wr_del = 1'b1;
        state_nxt  = S_DEL_TEST;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/bole_datapath.sv @@
// Datapath for the bounded ordered list engine: entry memory, count,
// request checks, move cursor and result registers. Depends on bole_pkg.
module bole_datapath
  import bole_pkg::*;
#(
  parameter int CAPACITY = 64
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  bole_cmd_t                 cmd,
  output bole_stat_t                stat,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic [COUNT_W-1:0]        out_entry_count,
  output logic signed [VALUE_W-1:0] out_removed_value
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] CAP_E = CMPW'(CAPACITY);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata_r;

  logic [CW-1:0]      occ_r;
  logic [CW-1:0]      occ_nxt;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      at_r;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] removed_r;
  logic [STAT_W-1:0]  status_r;
  logic               op_ins_r;
  logic               op_del_r;
  logic               clear_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [VALUE_W-1:0] out_removed_r;

  // Request check, evaluated on the accepting cycle.
  logic [CMPW-1:0]   pos_e;
  logic [CMPW-1:0]   occ_e;
  logic [CMPW-1:0]   at_e;
  logic              is_ins;
  logic              is_del;
  logic [STAT_W-1:0] chk_status;

  logic [CW:0]        idx_inc;
  logic [AW-1:0]      raddr;
  logic               rd_en;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic               wr_en;
  logic [31:0]        occ_wide;

  always_comb begin
    pos_e      = CMPW'(in_position);
    occ_e      = CMPW'(occ_r);
    at_e       = '0;
    is_ins     = 1'b0;
    is_del     = 1'b0;
    chk_status = ST_OK;
    case (in_kind)
      KIND_INS_FIRST: begin
        is_ins = 1'b1;
      end
      KIND_INS_LAST: begin
        is_ins = 1'b1;
        at_e   = occ_e;
      end
      KIND_INS_AT: begin
        is_ins = 1'b1;
        at_e   = pos_e;
      end
      KIND_DEL_FIRST: begin
        is_del = 1'b1;
      end
      KIND_DEL_LAST: begin
        is_del = 1'b1;
        at_e   = occ_e - CMPW'(1);
      end
      KIND_DEL_AT: begin
        is_del = 1'b1;
        at_e   = pos_e;
      end
      default: begin
      end
    endcase

    if (is_ins) begin
      if (at_e > occ_e) begin
        chk_status = ST_INVALID;
      end else if (occ_e >= CAP_E) begin
        chk_status = ST_FULL;
      end
    end else if (is_del) begin
      if (in_kind == KIND_DEL_AT) begin
        if (pos_e == '0 && occ_e == '0) begin
          chk_status = ST_EMPTY;
        end else if (pos_e >= occ_e) begin
          chk_status = ST_INVALID;
        end
      end else if (occ_e == '0) begin
        chk_status = ST_EMPTY;
      end
    end
  end

  assign idx_inc     = {1'b0, idx_r} + (CW + 1)'(1);
  assign stat.op_ins = op_ins_r;
  assign stat.op_del = op_del_r;
  assign stat.more   = op_ins_r ? (idx_r > at_r) : (idx_inc < {1'b0, occ_r});

  // One read port and one write port on the entry memory.
  always_comb begin
    rd_en = cmd.rd_ins | cmd.rd_at | cmd.rd_del;
    raddr = at_r[AW-1:0];
    if (cmd.rd_ins) begin
      raddr = AW'(idx_r - CW'(1));
    end else if (cmd.rd_del) begin
      raddr = idx_inc[AW-1:0];
    end
    wr_en = cmd.wr_ins | cmd.wr_del | cmd.wr_val;
    waddr = cmd.wr_val ? at_r[AW-1:0] : idx_r[AW-1:0];
    wdata = cmd.wr_val ? value_r : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (clear_r) begin
      occ_nxt = '0;
    end else if (op_ins_r) begin
      occ_nxt = occ_r + CW'(1);
    end else if (op_del_r) begin
      occ_nxt = occ_r - CW'(1);
    end
  end

  assign occ_wide = 32'(occ_nxt);

  // Request payload and cursor; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r  <= in_value;
      status_r <= chk_status;
      at_r     <= CW'(at_e);
      idx_r    <= occ_r;
    end else if (cmd.wr_ins) begin
      idx_r <= idx_r - CW'(1);
    end else if (cmd.cap) begin
      idx_r <= at_r;
    end else if (cmd.wr_del) begin
      idx_r <= idx_inc[CW-1:0];
    end
    if (cmd.cap) begin
      removed_r <= rdata_r;
    end
    if (cmd.finish) begin
      out_status_r  <= status_r;
      out_count_r   <= occ_wide[COUNT_W-1:0];
      out_removed_r <= op_del_r ? removed_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      op_ins_r    <= 1'b0;
      op_del_r    <= 1'b0;
      clear_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        op_ins_r <= is_ins && (chk_status == ST_OK);
        op_del_r <= is_del && (chk_status == ST_OK);
        clear_r  <= (in_kind == KIND_CLEAR);
      end
      if (cmd.finish) begin
        occ_r <= occ_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;
  assign out_removed_value = out_removed_r;

endmodule

@@ rtl/bounded_ordered_list_engine_top.sv @@
// Top level of the bounded ordered list engine.
// Joins bole_ctrl and bole_datapath; depends on bole_pkg.
//
// A request is taken at a rising edge with start high and busy low, and exactly
// one result follows, shown for one cycle with out_valid high; the receiver
// cannot stall it. The entries sit in a single-port-read, single-port-write
// memory, and every entry behind an insert or delete point is moved by a
// read and then a write. The result appears in the same cycle that busy
// falls. No clearing pass is needed after reset.
module bounded_ordered_list_engine_top
  import bole_pkg::*;
#(
  parameter int CAPACITY = 64
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic [COUNT_W-1:0]        out_entry_count,
  output logic signed [VALUE_W-1:0] out_removed_value
);

  bole_cmd_t  cmd;
  bole_stat_t stat;

  bole_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bole_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_removed_value (out_removed_value)
  );

endmodule

@@ rtl/bole_checker.sv @@
// Port-level checker for the bounded ordered list engine, bound to the top.
// Depends on bole_pkg and bounded_ordered_list_engine_top.
module bole_checker
  import bole_pkg::*;
#(
  parameter int CAPACITY = 64
)(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [STAT_W-1:0]         out_status,
  input logic [COUNT_W-1:0]        out_entry_count,
  input logic signed [VALUE_W-1:0] out_removed_value
);

  // An accepted request keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // Every request goes through a check state before its result, so results never come back to back.
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  // A result never shows while a request is still being worked on.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(busy, 1) || !busy)
    else $error("result while busy");

  // Failed requests report no removed value.
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_removed_value == '0))
    else $error("removed value on a failed request");

  // The count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_entry_count) <= CAPACITY))
    else $error("entry count above capacity");

endmodule

bind bounded_ordered_list_engine_top bole_checker #(
  .CAPACITY (CAPACITY)
) u_bole_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_entry_count   (out_entry_count),
  .out_removed_value (out_removed_value)
);

@@ test/bole_list_checker.sv @@
// Checker for the bounded ordered list engine: watches the request and result
// channels, keeps its own copy of the list and compares every result in order.
// Depends on bole_pkg.
`timescale 1ns / 100ps
module bole_list_checker
  import bole_pkg::*;
#(
  parameter int CAPACITY = 64
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic                      out_valid,
  input  logic [STAT_W-1:0]         out_status,
  input  logic [COUNT_W-1:0]        out_entry_count,
  input  logic signed [VALUE_W-1:0] out_removed_value,
  output int                        mismatches,
  output int                        outstanding,
  output int                        compared
);

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] removed;
  } list_result_t;

  logic signed [VALUE_W-1:0] contents[$];
  list_result_t              awaited_q[$];

  task automatic report(input string what, input logic [31:0] seen,
                        input logic [31:0] wanted);
    if (mismatches < 20) begin
      $display("MISMATCH %s: got %0h, wanted %0h at %0t", what, seen, wanted, $realtime);
    end
    mismatches++;
  endtask

  // Applies one request to the list copy and returns the result it must give.
  function automatic list_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic signed [VALUE_W-1:0] value,
                                                 input logic [POS_W-1:0] position);
    list_result_t r;
    int           at;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
        if (kind == KIND_INS_FIRST) at = 0;
        else if (kind == KIND_INS_LAST) at = contents.size();
        else at = int'(position);
        // A position past the end wins over a full list.
        if (at > contents.size()) r.status = ST_INVALID;
        else if (contents.size() >= CAPACITY) r.status = ST_FULL;
        else contents.insert(at, value);
      end
      KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT: begin
        if (kind == KIND_DEL_FIRST) at = 0;
        else if (kind == KIND_DEL_LAST) at = contents.size() - 1;
        else at = int'(position);
        // Delete at a nonzero position on an empty list is an index error.
        if (contents.size() == 0 && (kind != KIND_DEL_AT || position == 0)) begin
          r.status = ST_EMPTY;
        end else if (at >= contents.size()) begin
          r.status = ST_INVALID;
        end else begin
          r.removed = contents[at];
          contents.delete(at);
        end
      end
      KIND_CLEAR: contents.delete();
      default: ;
    endcase
    r.count = COUNT_W'(contents.size());
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      contents.delete();
      awaited_q.delete();
      outstanding <= 0;
    end else begin
      // The result of one request can share an edge with the next request.
      if (out_valid) begin
        if (awaited_q.size() == 0) begin
          report("result with no request pending", 32'(out_status), '0);
        end else begin
          want = awaited_q.pop_front();
          compared++;
          if (out_status !== want.status) begin
            report("status", 32'(out_status), 32'(want.status));
          end
          if (out_entry_count !== want.count) begin
            report("entry_count", 32'(out_entry_count), 32'(want.count));
          end
          if (out_removed_value !== want.removed) begin
            report("removed_value", out_removed_value, want.removed);
          end
        end
      end
      if (start && !busy) begin
        awaited_q.push_back(apply_request(in_kind, in_value, in_position));
      end
      outstanding <= awaited_q.size();
    end
  end

endmodule

@@ test/bounded_ordered_list_engine_top_test.sv @@
// Testbench top for the bounded ordered list engine: drives directed and random
// requests, runs the list between empty and full, and gives the verdict.
// Depends on bole_pkg, bounded_ordered_list_engine_top and bole_list_checker.
`timescale 1ns / 100ps
module bounded_ordered_list_engine_top_test
  import bole_pkg::*;
();

  localparam int CAPACITY    = 64;
  localparam int REQUESTS    = 1400;
  localparam int CALM_TAIL   = 200;
  localparam int STALL_LIMIT = 2000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [KIND_W-1:0]         in_kind;
  logic signed [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]          in_position;
  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic [COUNT_W-1:0]        out_entry_count;
  logic signed [VALUE_W-1:0] out_removed_value;

  int mismatches;
  int outstanding;
  int compared;
  int sent = 0;
  int fill = 0;
  int full_visits = 0;
  int stall_cycles = 0;
  bit idling = 1'b1;

  always #5 clk = ~clk;

  bounded_ordered_list_engine_top #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_removed_value(out_removed_value)
  );

  bole_list_checker #(.CAPACITY(CAPACITY)) list_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_removed_value(out_removed_value),
    .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
  );

  // The watchdog only counts cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Occupancy seen from the stimulus side, used to aim positions and to tell when the list is full or empty.
  function automatic int updated_fill(input logic [KIND_W-1:0] kind,
                                      input logic [POS_W-1:0] position, input int f);
    case (kind)
      KIND_INS_FIRST, KIND_INS_LAST: return (f < CAPACITY) ? f + 1 : f;
      KIND_INS_AT:    return (int'(position) <= f && f < CAPACITY) ? f + 1 : f;
      KIND_DEL_FIRST, KIND_DEL_LAST: return (f > 0) ? f - 1 : f;
      KIND_DEL_AT:    return (int'(position) < f) ? f - 1 : f;
      KIND_CLEAR:     return 0;
      default:        return f;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] insert_pos();
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, fill));
  endfunction

  function automatic logic [POS_W-1:0] delete_pos();
    if ($urandom_range(0, 9) == 0 || fill == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, fill - 1));
  endfunction

  // Holds the request until it is taken; start stays high for a following request.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] value,
                       input logic [POS_W-1:0] position);
    if (idling && sent < REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_value    <= value;
    in_position <= position;
    do @(posedge clk); while (busy);
    fill = updated_fill(kind, position, fill);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic fill_up();
    while (fill < CAPACITY) issue(KIND_W'($urandom_range(0, 2)), $urandom, insert_pos());
    full_visits++;
    issue(KIND_INS_FIRST, $urandom, POS_W'($urandom_range(0, 255)));
    issue(KIND_INS_AT, $urandom, insert_pos());
    issue(KIND_INS_AT, $urandom, POS_W'($urandom_range(CAPACITY + 1, 255)));
  endtask

  task automatic drain_out();
    while (fill > 0) issue(KIND_W'($urandom_range(3, 5)), $urandom, delete_pos());
    issue(KIND_DEL_LAST, $urandom, POS_W'($urandom_range(0, 255)));
    issue(KIND_DEL_AT, $urandom, POS_W'($urandom_range(0, 255)));
  endtask

  task automatic churn(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        issue(KIND_W'($urandom_range(0, 2)), $urandom, insert_pos());
      end else if (r < 90) begin
        issue(KIND_W'($urandom_range(3, 5)), $urandom, delete_pos());
      end else if (r < 96) begin
        issue(KIND_W'($urandom_range(0, 7)), $urandom, POS_W'($urandom_range(0, 255)));
      end else if (r < 98) begin
        issue(KIND_CLEAR, $urandom, POS_W'($urandom_range(0, 255)));
      end else begin
        issue(KIND_UNUSED, $urandom, POS_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_kind     <= KIND_INS_FIRST;
    in_value    <= '0;
    in_position <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list corners, then a small list built from the value extremes.
    issue(KIND_DEL_FIRST, 32'sh7FFFFFFF, 8'd0);
    issue(KIND_DEL_LAST, $urandom, 8'd255);
    issue(KIND_DEL_AT, $urandom, 8'd0);
    issue(KIND_DEL_AT, $urandom, 8'd255);
    issue(KIND_INS_AT, $urandom, 8'd1);
    issue(KIND_INS_AT, $urandom, 8'd255);
    issue(KIND_INS_FIRST, 32'sh80000000, 8'd255);
    issue(KIND_INS_LAST, 32'sh7FFFFFFF, 8'd0);
    issue(KIND_INS_AT, -32'sd1, 8'd1);
    issue(KIND_INS_AT, 32'sd0, 8'd3);
    issue(KIND_INS_AT, 32'sh5A5AA5A5, 8'd0);
    issue(KIND_DEL_AT, $urandom, 8'd5);
    issue(KIND_DEL_AT, $urandom, 8'd2);
    issue(KIND_DEL_FIRST, $urandom, 8'd0);
    issue(KIND_DEL_LAST, $urandom, 8'd0);
    issue(KIND_UNUSED, $urandom, 8'd0);
    issue(KIND_CLEAR, $urandom, 8'd0);
    issue(KIND_DEL_FIRST, $urandom, 8'd0);
    issue(KIND_CLEAR, $urandom, 8'd0);
    settle();

    while (sent < REQUESTS) begin
      idling = ($urandom_range(0, 1) == 1);
      case ($urandom_range(0, 3))
        0: fill_up();
        1: drain_out();
        default: churn($urandom_range(10, 40));
      endcase
      if ($urandom_range(0, 9) == 0) settle();
    end
    settle();
    repeat (8) @(posedge clk);

    $display("Drove %0d requests, checked %0d results and filled the list %0d times.",
             sent, compared, full_visits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
